[sv/assert_macros.svh]
// RTL assertion helpers. Both need clk_i in scope; ASSERT_CLK also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/gha_pkg.sv]
package gha_pkg;

  localparam int ENTRIES      = 1024;
  localparam int GEN_BITS     = 15;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Port field widths.
  localparam int KIND_W   = 2;
  localparam int HIDX_W   = 10;
  localparam int HGEN_W   = 15;
  localparam int HPAY_W   = 32;
  localparam int TAG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_GET    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]    link;
    logic [GEN_BITS-1:0] gen;
    logic                active;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ent_req_t;

  typedef struct packed {
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [PAYLOAD_BITS-1:0] wdata;
  } pay_req_t;

endpackage

[sv/gha_ram.sv]
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/gha_core.sv]
`include "assert_macros.svh"

module gha_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [gha_pkg::KIND_W-1:0]      kind_i,
  input  logic [gha_pkg::HIDX_W-1:0]      handle_index_i,
  input  logic [gha_pkg::HGEN_W-1:0]      handle_generation_i,
  input  logic [gha_pkg::HPAY_W-1:0]      payload_i,
  input  logic [gha_pkg::TAG_W-1:0]       type_tag_i,
  output logic                            done_o,
  output logic [gha_pkg::STATUS_W-1:0]    status_o,
  output logic [gha_pkg::HIDX_W-1:0]      out_index_o,
  output logic [gha_pkg::HGEN_W-1:0]      out_generation_o,
  output logic [gha_pkg::TAG_W-1:0]       out_type_o,
  output logic [gha_pkg::HPAY_W-1:0]      payload_out_o,
  output logic [gha_pkg::COUNT_W-1:0]     active_count_o,
  output gha_pkg::ent_req_t               ent_req_o,
  input  gha_pkg::entry_t                 ent_rdata_i,
  output gha_pkg::pay_req_t               pay_req_o,
  input  logic [gha_pkg::PAYLOAD_BITS-1:0] pay_rdata_i
);

  gha_pkg::state_e state_q, state_d;
  logic [gha_pkg::CNT_W-1:0] head_q, head_d;
  logic [gha_pkg::CNT_W-1:0] live_q, live_d;
  // Entries at or above the fill mark are unwritten; the core reads defaults for them.
  logic [gha_pkg::CNT_W-1:0] fill_q, fill_d;
  logic done_q, done_d;

  gha_pkg::kind_e                   kind_q;
  logic [gha_pkg::IDX_W-1:0]        addr_q;
  logic [gha_pkg::HIDX_W-1:0]       hidx_q;
  logic [gha_pkg::HGEN_W-1:0]       hgen_q;
  logic [gha_pkg::HPAY_W-1:0]       pay_q;
  logic [gha_pkg::TAG_W-1:0]        tag_q;

  gha_pkg::status_e                 status_d, status_q;
  logic [gha_pkg::HIDX_W-1:0]       oidx_d, oidx_q;
  logic [gha_pkg::HGEN_W-1:0]       ogen_d, ogen_q;
  logic [gha_pkg::TAG_W-1:0]        otype_d, otype_q;
  logic [gha_pkg::HPAY_W-1:0]       opay_d, opay_q;

  logic                             accept;
  gha_pkg::kind_e                   kind_in;
  logic [gha_pkg::IDX_W-1:0]        rd_addr;
  gha_pkg::entry_t                  cur;
  logic [gha_pkg::GEN_BITS-1:0]     gen_nxt;
  logic                             in_range;
  logic                             full;

  assign busy    = (state_q == gha_pkg::S_EXEC);
  assign accept  = start && !busy;
  assign kind_in = gha_pkg::kind_e'(kind_i);
  assign rd_addr = (kind_in == gha_pkg::OP_ADD) ? head_q[gha_pkg::IDX_W-1:0]
                                                : gha_pkg::IDX_W'(handle_index_i);

  always_comb begin
    if (gha_pkg::CNT_W'(addr_q) < fill_q) begin
      cur = ent_rdata_i;
    end else begin
      cur.link   = gha_pkg::CNT_W'(addr_q) + gha_pkg::CNT_W'(1);
      cur.gen    = gha_pkg::GEN_BITS'(1);
      cur.active = 1'b0;
    end
  end

  always_comb begin
    gen_nxt = cur.gen + gha_pkg::GEN_BITS'(1);
    if (gen_nxt == '0) begin
      gen_nxt = gha_pkg::GEN_BITS'(1);
    end
  end

  assign in_range = (32'(hidx_q) < 32'(gha_pkg::ENTRIES));
  assign full     = (live_q >= gha_pkg::CNT_W'(gha_pkg::ENTRIES)) ||
                    (head_q >= gha_pkg::CNT_W'(gha_pkg::ENTRIES));

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    live_d   = live_q;
    fill_d   = fill_q;
    done_d   = 1'b0;
    status_d = gha_pkg::ST_OK;
    oidx_d   = '0;
    ogen_d   = '0;
    otype_d  = '0;
    opay_d   = '0;

    ent_req_o.re    = accept;
    ent_req_o.raddr = rd_addr;
    ent_req_o.we    = 1'b0;
    ent_req_o.waddr = addr_q;
    ent_req_o.wdata = cur;
    pay_req_o.re    = accept;
    pay_req_o.raddr = rd_addr;
    pay_req_o.we    = 1'b0;
    pay_req_o.waddr = addr_q;
    pay_req_o.wdata = gha_pkg::PAYLOAD_BITS'(pay_q);

    case (state_q)
      gha_pkg::S_IDLE: begin
        if (accept) begin
          state_d = gha_pkg::S_EXEC;
        end
      end
      gha_pkg::S_EXEC: begin
        state_d = gha_pkg::S_IDLE;
        done_d  = 1'b1;
        if (kind_q == gha_pkg::OP_ADD) begin
          if (full) begin
            status_d = gha_pkg::ST_FULL;
          end else begin
            head_d                 = cur.link;
            ent_req_o.we           = 1'b1;
            ent_req_o.wdata.link   = '0;
            ent_req_o.wdata.gen    = gen_nxt;
            ent_req_o.wdata.active = 1'b1;
            pay_req_o.we           = 1'b1;
            live_d                 = live_q + gha_pkg::CNT_W'(1);
            if (gha_pkg::CNT_W'(addr_q) == fill_q) begin
              fill_d = fill_q + gha_pkg::CNT_W'(1);
            end
            oidx_d  = gha_pkg::HIDX_W'(addr_q);
            ogen_d  = gha_pkg::HGEN_W'(gen_nxt);
            otype_d = tag_q;
          end
        end else if (!in_range) begin
          status_d = gha_pkg::ST_STALE;
        end else begin
          case (kind_q)
            gha_pkg::OP_UPDATE: begin
              pay_req_o.we = 1'b1;
            end
            gha_pkg::OP_REMOVE: begin
              if (!cur.active) begin
                status_d = gha_pkg::ST_STALE;
              end else begin
                ent_req_o.we           = 1'b1;
                ent_req_o.wdata.link   = head_q;
                ent_req_o.wdata.active = 1'b0;
                head_d                 = gha_pkg::CNT_W'(addr_q);
                if (live_q != '0) begin
                  live_d = live_q - gha_pkg::CNT_W'(1);
                end
              end
            end
            gha_pkg::OP_GET: begin
              if (cur.active && (cur.gen == gha_pkg::GEN_BITS'(hgen_q))) begin
                opay_d = gha_pkg::HPAY_W'(pay_rdata_i);
              end else begin
                status_d = gha_pkg::ST_STALE;
              end
            end
            default: begin
              status_d = gha_pkg::ST_STALE;
            end
          endcase
        end
      end
      default: begin
        state_d = gha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gha_pkg::S_IDLE;
      head_q  <= '0;
      live_q  <= '0;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      live_q  <= live_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_in;
      addr_q <= rd_addr;
      hidx_q <= handle_index_i;
      hgen_q <= handle_generation_i;
      pay_q  <= payload_i;
      tag_q  <= type_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gha_pkg::S_EXEC) begin
      status_q <= status_d;
      oidx_q   <= oidx_d;
      ogen_q   <= ogen_d;
      otype_q  <= otype_d;
      opay_q   <= opay_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_index_o      = oidx_q;
  assign out_generation_o = ogen_q;
  assign out_type_o       = otype_q;
  assign payload_out_o    = opay_q;
  assign active_count_o   = gha_pkg::COUNT_W'(live_q);

  `ASSERT_ALWAYS(a_done_not_busy, !(done_o && busy), "result beat while still busy")
  `ASSERT_CLK(a_accept_busy, accept |=> busy, "accepted beat did not start execution")
  `ASSERT_CLK(a_busy_done, busy |=> done_o, "execution did not produce a result beat")
  `ASSERT_CLK(a_live_bound, live_q <= gha_pkg::CNT_W'(gha_pkg::ENTRIES),
              "active count exceeds table size")
  `ASSERT_CLK(a_live_fill, live_q <= fill_q, "more active entries than ever written")

endmodule

[sv/generational_handle_allocator.sv]
// Result: each accepted start passes through the execute state, and the result beat is
// registered out of that state and lasts one cycle.
// Operations: no new start is taken while busy; busy is high for the single cycle in
// which the entry memory read is consumed and, when the entry changes, written back.
// Reset: asynchronous, active low; the table is empty at once, with no clearing pass.
// The receiver cannot stall: every result beat is taken in its single strobe cycle.
module generational_handle_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [gha_pkg::KIND_W-1:0]   kind_i,
  input  logic [gha_pkg::HIDX_W-1:0]   handle_index_i,
  input  logic [gha_pkg::HGEN_W-1:0]   handle_generation_i,
  input  logic [gha_pkg::HPAY_W-1:0]   payload_i,
  input  logic [gha_pkg::TAG_W-1:0]    type_tag_i,
  output logic                         done_o,
  output logic [gha_pkg::STATUS_W-1:0] status_o,
  output logic [gha_pkg::HIDX_W-1:0]   out_index_o,
  output logic [gha_pkg::HGEN_W-1:0]   out_generation_o,
  output logic [gha_pkg::TAG_W-1:0]    out_type_o,
  output logic [gha_pkg::HPAY_W-1:0]   payload_out_o,
  output logic [gha_pkg::COUNT_W-1:0]  active_count_o
);

  gha_pkg::ent_req_t                ent_req;
  gha_pkg::entry_t                  ent_rdata;
  gha_pkg::pay_req_t                pay_req;
  logic [gha_pkg::PAYLOAD_BITS-1:0] pay_rdata;

  gha_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .kind_i              (kind_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .payload_i           (payload_i),
    .type_tag_i          (type_tag_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .out_index_o         (out_index_o),
    .out_generation_o    (out_generation_o),
    .out_type_o          (out_type_o),
    .payload_out_o       (payload_out_o),
    .active_count_o      (active_count_o),
    .ent_req_o           (ent_req),
    .ent_rdata_i         (ent_rdata),
    .pay_req_o           (pay_req),
    .pay_rdata_i         (pay_rdata)
  );

  gha_ram #(
    .WIDTH ($bits(gha_pkg::entry_t)),
    .DEPTH (gha_pkg::ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .re_i    (ent_req.re),
    .raddr_i (ent_req.raddr),
    .rdata_o (ent_rdata),
    .we_i    (ent_req.we),
    .waddr_i (ent_req.waddr),
    .wdata_i (ent_req.wdata)
  );

  gha_ram #(
    .WIDTH (gha_pkg::PAYLOAD_BITS),
    .DEPTH (gha_pkg::ENTRIES)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .re_i    (pay_req.re),
    .raddr_i (pay_req.raddr),
    .rdata_o (pay_rdata),
    .we_i    (pay_req.we),
    .waddr_i (pay_req.waddr),
    .wdata_i (pay_req.wdata)
  );

endmodule

[dv/generational_handle_allocator_tb.sv]
`timescale 1ns / 100ps

module generational_handle_allocator_tb;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int REUSE_ROUNDS = 20;

  typedef struct packed {
    gha_pkg::status_e                 status;
    logic [gha_pkg::HIDX_W-1:0]       index;
    logic [gha_pkg::HGEN_W-1:0]       gen_no;
    logic [gha_pkg::TAG_W-1:0]        tag;
    logic [gha_pkg::HPAY_W-1:0]       word;
    logic [gha_pkg::COUNT_W-1:0]      count;
  } reply_t;

  class handle_table_model;
    logic [gha_pkg::CNT_W-1:0]        next_link [gha_pkg::ENTRIES];
    logic [gha_pkg::GEN_BITS-1:0]     gen_of [gha_pkg::ENTRIES];
    bit                               live_of [gha_pkg::ENTRIES];
    logic [gha_pkg::PAYLOAD_BITS-1:0] word_of [gha_pkg::ENTRIES];
    logic [gha_pkg::CNT_W-1:0]        free_head;
    logic [gha_pkg::CNT_W-1:0]        live_total;
    reply_t                           pending_replies [$];
    int                               mismatches;

    function new();
      for (int i = 0; i < gha_pkg::ENTRIES; i++) begin
        next_link[i] = gha_pkg::CNT_W'(i + 1);
        gen_of[i]    = gha_pkg::GEN_BITS'(1);
        live_of[i]   = 1'b0;
        word_of[i]   = '0;
      end
      free_head  = '0;
      live_total = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Applies one accepted operation to the table and queues the reply it must produce.
    function void record_op(gha_pkg::kind_e op, logic [gha_pkg::HIDX_W-1:0] idx,
                            logic [gha_pkg::HGEN_W-1:0] hgen,
                            logic [gha_pkg::HPAY_W-1:0] word,
                            logic [gha_pkg::TAG_W-1:0] tag);
      reply_t                       r;
      logic [gha_pkg::GEN_BITS-1:0] g;
      int                           h;
      r = '0;
      r.status = gha_pkg::ST_OK;
      if (op == gha_pkg::OP_ADD) begin
        h = int'(free_head);
        if (live_total >= gha_pkg::CNT_W'(gha_pkg::ENTRIES) ||
            free_head >= gha_pkg::CNT_W'(gha_pkg::ENTRIES)) begin
          r.status = gha_pkg::ST_FULL;
        end else begin
          g = gen_of[h] + gha_pkg::GEN_BITS'(1);
          // The generation never takes the value zero.
          if (g == '0) g = gha_pkg::GEN_BITS'(1);
          free_head    = next_link[h];
          next_link[h] = '0;
          gen_of[h]    = g;
          live_of[h]   = 1'b1;
          word_of[h]   = word;
          live_total++;
          r.index  = gha_pkg::HIDX_W'(h);
          r.gen_no = g;
          r.tag    = tag;
        end
      end else if (int'(idx) >= gha_pkg::ENTRIES) begin
        r.status = gha_pkg::ST_STALE;
      end else begin
        case (op)
          gha_pkg::OP_UPDATE: word_of[idx] = word;
          gha_pkg::OP_REMOVE: begin
            if (!live_of[idx]) begin
              r.status = gha_pkg::ST_STALE;
            end else begin
              next_link[idx] = free_head;
              live_of[idx]   = 1'b0;
              free_head      = gha_pkg::CNT_W'(idx);
              if (live_total > 0) live_total--;
            end
          end
          default: begin
            if (live_of[idx] && gen_of[idx] == hgen) r.word = word_of[idx];
            else r.status = gha_pkg::ST_STALE;
          end
        endcase
      end
      r.count = live_total;
      pending_replies.push_back(r);
    endfunction

    function void compare_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        flag($sformatf("unexpected result beat: status %0d index %0d gen %0d", got.status,
                       got.index, got.gen_no));
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.index !== want.index ||
          got.gen_no !== want.gen_no || got.tag !== want.tag ||
          got.word !== want.word || got.count !== want.count) begin
        flag($sformatf({"mismatch: expected status %0d index %0d gen %0d type %0d ",
                        "payload %h count %0d, got status %0d index %0d gen %0d type %0d ",
                        "payload %h count %0d"},
                       want.status, want.index, want.gen_no, want.tag, want.word, want.count,
                       got.status, got.index, got.gen_no, got.tag, got.word, got.count));
      end
    endfunction

    function int pick_live();
      int s;
      s = $urandom_range(gha_pkg::ENTRIES - 1);
      for (int k = 0; k < gha_pkg::ENTRIES; k++) begin
        if (live_of[(s + k) % gha_pkg::ENTRIES]) return (s + k) % gha_pkg::ENTRIES;
      end
      return -1;
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [gha_pkg::KIND_W-1:0]     kind_i;
  logic [gha_pkg::HIDX_W-1:0]     handle_index_i;
  logic [gha_pkg::HGEN_W-1:0]     handle_generation_i;
  logic [gha_pkg::HPAY_W-1:0]     payload_i;
  logic [gha_pkg::TAG_W-1:0]      type_tag_i;
  logic                           done_o;
  logic [gha_pkg::STATUS_W-1:0]   status_o;
  logic [gha_pkg::HIDX_W-1:0]     out_index_o;
  logic [gha_pkg::HGEN_W-1:0]     out_generation_o;
  logic [gha_pkg::TAG_W-1:0]      out_type_o;
  logic [gha_pkg::HPAY_W-1:0]     payload_out_o;
  logic [gha_pkg::COUNT_W-1:0]    active_count_o;

  handle_table_model tbl = new();
  int sender_idle_pct;
  int cycles;

  generational_handle_allocator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .kind_i              (kind_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .payload_i           (payload_i),
    .type_tag_i          (type_tag_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .out_index_o         (out_index_o),
    .out_generation_o    (out_generation_o),
    .out_type_o          (out_type_o),
    .payload_out_o       (payload_out_o),
    .active_count_o      (active_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin : reply_monitor
    reply_t got;
    if (rst_ni && done_o) begin
      got.status = gha_pkg::status_e'(status_o);
      got.index  = out_index_o;
      got.gen_no = out_generation_o;
      got.tag    = out_type_o;
      got.word   = payload_out_o;
      got.count  = active_count_o;
      tbl.compare_reply(got);
    end
  end

  function automatic logic [gha_pkg::HIDX_W-1:0] rnd_idx();
    return gha_pkg::HIDX_W'($urandom);
  endfunction

  function automatic logic [gha_pkg::HGEN_W-1:0] rnd_gen();
    return gha_pkg::HGEN_W'($urandom);
  endfunction

  function automatic logic [gha_pkg::TAG_W-1:0] rnd_tag();
    return gha_pkg::TAG_W'($urandom);
  endfunction

  // Called at a rising edge; returns at a rising edge after the beat is taken.
  task automatic issue(gha_pkg::kind_e op, logic [gha_pkg::HIDX_W-1:0] idx,
                       logic [gha_pkg::HGEN_W-1:0] hgen, logic [gha_pkg::HPAY_W-1:0] word,
                       logic [gha_pkg::TAG_W-1:0] tag);
    int gap;
    start               <= 1'b1;
    kind_i              <= op;
    handle_index_i      <= idx;
    handle_generation_i <= hgen;
    payload_i           <= word;
    type_tag_i          <= tag;
    do @(posedge clk_i); while (busy);
    tbl.record_op(op, idx, hgen, word, tag);
    gap = 0;
    while (gap < 12 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue_add();
    issue(gha_pkg::OP_ADD, rnd_idx(), rnd_gen(), $urandom, rnd_tag());
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (tbl.pending_replies.size() != 0);
  endtask

  task automatic random_ops(int n_ops);
    int r;
    int pick;
    repeat (n_ops) begin
      r    = $urandom_range(99);
      pick = tbl.pick_live();
      if (pick < 0 || r < 25) begin
        issue_add();
      end else if (r < 45) begin
        issue(gha_pkg::OP_GET, gha_pkg::HIDX_W'(pick), tbl.gen_of[pick], $urandom, rnd_tag());
      end else if (r < 60) begin
        issue(gha_pkg::OP_REMOVE, gha_pkg::HIDX_W'(pick), rnd_gen(), $urandom, rnd_tag());
      end else if (r < 70) begin
        issue(gha_pkg::OP_UPDATE, gha_pkg::HIDX_W'(pick), rnd_gen(), $urandom, rnd_tag());
      end else if (r < 80) begin
        // A handle that is off by one generation bit must be refused.
        issue(gha_pkg::OP_GET, gha_pkg::HIDX_W'(pick),
              tbl.gen_of[pick] ^ (gha_pkg::HGEN_W'(1) << $urandom_range(gha_pkg::HGEN_W - 1)),
              $urandom, rnd_tag());
      end else begin
        issue(gha_pkg::kind_e'($urandom_range(3)), rnd_idx(), rnd_gen(), $urandom, rnd_tag());
      end
    end
  endtask

  initial begin
    int w;
    rst_ni              = 1'b0;
    start               = 1'b0;
    kind_i              = gha_pkg::OP_ADD;
    handle_index_i      = '0;
    handle_generation_i = '0;
    payload_i           = '0;
    type_tag_i          = '0;
    sender_idle_pct     = 0;
    cycles              = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(gha_pkg::OP_ADD, 10'd0, 15'd0, 32'h0000_0000, 5'd0);
    issue(gha_pkg::OP_ADD, 10'h3ff, 15'h7fff, 32'hffff_ffff, 5'd31);
    issue(gha_pkg::OP_GET, 10'd0, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd1, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd1, 15'h7fff, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd0, 15'd0, 32'd0, 5'd0);
    // Update of a free entry still writes it; remove of a free entry is refused.
    issue(gha_pkg::OP_UPDATE, 10'h3ff, 15'd0, 32'ha5a5_a5a5, 5'd0);
    issue(gha_pkg::OP_REMOVE, 10'h3ff, 15'd1, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'h3ff, 15'd1, 32'd0, 5'd0);
    issue(gha_pkg::OP_UPDATE, 10'd0, 15'd0, 32'h1234_5678, 5'd0);
    issue(gha_pkg::OP_GET, 10'd0, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_REMOVE, 10'd0, 15'h7fff, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd0, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_REMOVE, 10'd0, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_ADD, 10'd0, 15'd0, 32'h5a5a_5a5a, 5'b10101);
    issue(gha_pkg::OP_GET, 10'd0, 15'd2, 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd0, 15'd3, 32'd0, 5'd0);
    issue(gha_pkg::OP_REMOVE, 10'd1, 15'd0, 32'd0, 5'd0);
    issue(gha_pkg::OP_REMOVE, 10'd0, 15'd0, 32'd0, 5'd0);
    issue(gha_pkg::OP_ADD, 10'd0, 15'd0, 32'h0f0f_0f0f, 5'd1);
    issue(gha_pkg::OP_ADD, 10'd0, 15'd0, 32'hf0f0_f0f0, 5'd2);
    issue(gha_pkg::OP_ADD, 10'd0, 15'd0, 32'h8000_0001, 5'd16);
    drain_results();

    // Cycle one entry through several generations.
    w = int'(tbl.free_head);
    issue_add();
    repeat (REUSE_ROUNDS) begin
      issue(gha_pkg::OP_REMOVE, gha_pkg::HIDX_W'(w), rnd_gen(), $urandom, rnd_tag());
      issue_add();
    end
    issue(gha_pkg::OP_GET, gha_pkg::HIDX_W'(w), tbl.gen_of[w], 32'd0, 5'd0);
    drain_results();

    sender_idle_pct = 25;
    while (tbl.live_total < gha_pkg::ENTRIES) issue_add();
    issue_add();
    issue_add();
    issue(gha_pkg::OP_GET, 10'h3ff, tbl.gen_of[10'h3ff], 32'd0, 5'd0);
    issue(gha_pkg::OP_UPDATE, 10'h3ff, 15'd0, $urandom, 5'd0);
    issue(gha_pkg::OP_GET, 10'h3ff, tbl.gen_of[10'h3ff], 32'd0, 5'd0);
    issue(gha_pkg::OP_GET, 10'd0, tbl.gen_of[0], 32'd0, 5'd0);
    drain_results();

    sender_idle_pct = 72;
    repeat (200) begin
      issue(gha_pkg::OP_REMOVE, gha_pkg::HIDX_W'(tbl.pick_live()), rnd_gen(), $urandom,
            rnd_tag());
    end
    random_ops(100);
    drain_results();

    sender_idle_pct = 0;
    random_ops(120);
    drain_results();

    sender_idle_pct = 25;
    random_ops(100);
    drain_results();

    repeat (8) @(posedge clk_i);
    if (tbl.pending_replies.size() != 0) tbl.flag("expected results never arrived");
    if (tbl.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
